// ----- rtl/rgb_voice_command_controller_top_assert.svh -----
// ----------------------------------------------------------------------------
// RGB voice command controller assertion macros
// Concurrent assertion helpers for the controller, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RGB_VOICE_COMMAND_CONTROLLER_TOP_ASSERT_SVH
`define RGB_VOICE_COMMAND_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define RVCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define RVCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RVCC_ASSERT(lbl, prop, msg)
`define RVCC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/rvcc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB voice command controller package
// Payload types, register map, command codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rvcc_pkg;

  // One received command frame.
  typedef struct packed {
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
  } frame_t;

  // One result: colour after the frame and what the frame did.
  typedef struct packed {
    logic [7:0] pwm_red;
    logic [7:0] pwm_green;
    logic [7:0] pwm_blue;
    logic       color_written;
    logic [2:0] frame_status;
  } result_t;

  typedef enum logic [2:0] {
    ST_APPLIED = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_MANUAL  = 3'd2,
    ST_AUTO    = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  // Register map: byte address is four times the index.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_VOICE_ENABLED   = 3'd0;
  localparam logic [2:0] REG_WHITE_PRESET    = 3'd1;
  localparam logic [2:0] REG_WARM_PRESET     = 3'd2;
  localparam logic [2:0] REG_READING_PRESET  = 3'd3;
  localparam logic [2:0] REG_SLEEPING_PRESET = 3'd4;

  // Command codes.
  localparam logic [7:0] CMD_WHITE    = 8'hA3;
  localparam logic [7:0] CMD_OFF_A    = 8'hA4;
  localparam logic [7:0] CMD_BRIGHTER = 8'hA7;
  localparam logic [7:0] CMD_DIMMER   = 8'hA8;
  localparam logic [7:0] CMD_WARM     = 8'hA9;
  localparam logic [7:0] CMD_READING  = 8'h10;
  localparam logic [7:0] CMD_OFF_B    = 8'h11;
  localparam logic [7:0] CMD_SLEEPING = 8'h12;
  localparam logic [7:0] CMD_OFF_C    = 8'h13;
  localparam logic [7:0] CMD_MANUAL   = 8'hD2;
  localparam logic [7:0] CMD_AUTO     = 8'hD1;

  localparam logic [7:0] OFF_LEVEL = 8'd255;
  localparam logic [7:0] GRAY_STEP = 8'd40;

endpackage

`default_nettype wire

// ----- rtl/rgb_voice_command_controller_top.sv -----
// ----------------------------------------------------------------------------
// RGB voice command controller
// Decodes four-byte voice command frames and keeps the colour of a
// common-anode RGB LED, reporting the colour after every frame.
// ----------------------------------------------------------------------------
//
//   Channel  | Signals                                   | Payload
//   ---------+-------------------------------------------+------------------
//   frame    | frame_valid, frame_stall, frame           | four command bytes
//   result   | result_valid, result_stall, result        | colour and status
//   config   | psel, penable, pwrite, paddr, pwdata,     | five registers at
//            | prdata, pready                            | byte addresses 4*i
//
// Every frame goes from its transfer to its result via the input register and
// then the result register. A new frame can be taken in every cycle while the
// result is not stalled; the rate is set by the single colour update between
// the two registers. Reset is synchronous and returns the LED to off (255 on
// every channel) with voice mode enabled. When the result is stalled, the
// input register still takes one more frame before the frame channel stalls.
//
`default_nettype none

module rgb_voice_command_controller_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Frame channel
  input  wire logic                          frame_valid,
  output logic                               frame_stall,
  input  wire rvcc_pkg::frame_t              frame,
  // Result channel
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output rvcc_pkg::result_t                  result,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rvcc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rvcc_pkg::DATA_W-1:0]   pwdata,
  output logic      [rvcc_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  import rvcc_pkg::*;

  // Divides a channel by five after scaling it by four. The reciprocal
  // 205/1024 is exact for every numerator below 1024.
  function automatic logic [7:0] scale_down(input logic [7:0] v);
    logic [9:0]  times4;
    logic [17:0] prod;
    begin
      times4 = {v, 2'b00};
      prod   = {8'd0, times4} * 18'd205;
      return prod[17:10];
    end
  endfunction

  // Multiplies a channel by five quarters and caps it at the off level.
  function automatic logic [7:0] scale_up(input logic [7:0] v);
    logic [10:0] prod;
    logic [8:0]  quarter;
    begin
      prod    = {3'd0, v} * 11'd5;
      quarter = prod[10:2];
      return (quarter > {1'b0, OFF_LEVEL}) ? OFF_LEVEL : quarter[7:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers. The user must change them only while no frame is
  // in flight; the block itself does not enforce this. The colour logic reads them directly.
  // --------------------------------------------------------------------------
  logic        voice_enabled;
  logic [23:0] white_preset;
  logic [23:0] warm_preset;
  logic [23:0] reading_preset;
  logic [23:0] sleeping_preset;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_enabled   <= 1'b1;
      white_preset    <= '0;
      warm_preset     <= '0;
      reading_preset  <= '0;
      sleeping_preset <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VOICE_ENABLED:   voice_enabled   <= pwdata[0];
        REG_WHITE_PRESET:    white_preset    <= pwdata[23:0];
        REG_WARM_PRESET:     warm_preset     <= pwdata[23:0];
        REG_READING_PRESET:  reading_preset  <= pwdata[23:0];
        REG_SLEEPING_PRESET: sleeping_preset <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_VOICE_ENABLED:   prdata = {31'd0, voice_enabled};
      REG_WHITE_PRESET:    prdata = {8'd0, white_preset};
      REG_WARM_PRESET:     prdata = {8'd0, warm_preset};
      REG_READING_PRESET:  prdata = {8'd0, reading_preset};
      REG_SLEEPING_PRESET: prdata = {8'd0, sleeping_preset};
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register. It advances whenever the result register is empty or its
  // content is transferred in the same cycle.
  // --------------------------------------------------------------------------
  logic   in_valid;
  frame_t in_frame;
  logic   in_advance;

  assign in_advance  = in_valid && (!result_valid || !result_stall);
  assign frame_stall = in_valid && !in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame_valid && !frame_stall) begin
      in_valid <= 1'b1;
    end else if (in_advance) begin
      in_valid <= 1'b0;
    end
    if (frame_valid && !frame_stall) begin
      in_frame <= frame;
    end
  end

  // --------------------------------------------------------------------------
  // Colour update for the frame in the input register.
  // --------------------------------------------------------------------------
  logic [7:0] held_red;
  logic [7:0] held_green;
  logic [7:0] held_blue;
  logic [7:0] held_red_next;
  logic [7:0] held_green_next;
  logic [7:0] held_blue_next;
  status_t    status_next;

  logic       bytes_equal;
  logic       is_gray;
  logic [7:0] code;
  logic [7:0] gray_up;
  logic [7:0] gray_down;
  logic [8:0] gray_sum;

  assign code        = in_frame.frame_byte0;
  assign bytes_equal = (in_frame.frame_byte0 == in_frame.frame_byte1) &&
                       (in_frame.frame_byte0 == in_frame.frame_byte2) &&
                       (in_frame.frame_byte0 == in_frame.frame_byte3);
  assign is_gray     = (held_red == held_green) && (held_blue == held_green);

  // Gray steps saturate at full on and at off.
  assign gray_up   = (held_red > GRAY_STEP) ? (held_red - GRAY_STEP) : 8'd0;
  assign gray_sum  = {1'b0, held_red} + {1'b0, GRAY_STEP};
  assign gray_down = (gray_sum > {1'b0, OFF_LEVEL}) ? OFF_LEVEL : gray_sum[7:0];

  always_comb begin
    held_red_next   = held_red;
    held_green_next = held_green;
    held_blue_next  = held_blue;
    status_next     = ST_UNKNOWN;
    if (!voice_enabled) begin
      status_next = ST_IGNORED;
    end else if (bytes_equal) begin
      status_next = ST_APPLIED;
      case (code)
        CMD_WHITE: begin
          {held_red_next, held_green_next, held_blue_next} = white_preset;
        end
        CMD_WARM: begin
          {held_red_next, held_green_next, held_blue_next} = warm_preset;
        end
        CMD_READING: begin
          {held_red_next, held_green_next, held_blue_next} = reading_preset;
        end
        CMD_SLEEPING: begin
          {held_red_next, held_green_next, held_blue_next} = sleeping_preset;
        end
        CMD_OFF_A, CMD_OFF_B, CMD_OFF_C: begin
          held_red_next   = OFF_LEVEL;
          held_green_next = OFF_LEVEL;
          held_blue_next  = OFF_LEVEL;
        end
        CMD_BRIGHTER: begin
          if (is_gray) begin
            held_red_next   = gray_up;
            held_green_next = gray_up;
            held_blue_next  = gray_up;
          end else begin
            held_red_next   = scale_down(held_red);
            held_green_next = scale_down(held_green);
            held_blue_next  = scale_down(held_blue);
          end
        end
        CMD_DIMMER: begin
          if (is_gray) begin
            held_red_next   = gray_down;
            held_green_next = gray_down;
            held_blue_next  = gray_down;
          end else begin
            held_red_next   = scale_up(held_red);
            held_green_next = scale_up(held_green);
            held_blue_next  = scale_up(held_blue);
          end
        end
        CMD_MANUAL: status_next = ST_MANUAL;
        CMD_AUTO:   status_next = ST_AUTO;
        default:    status_next = ST_UNKNOWN;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Held colour and result register, both loaded as the frame leaves the
  // input register, so the next frame sees the updated colour.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      held_red     <= OFF_LEVEL;
      held_green   <= OFF_LEVEL;
      held_blue    <= OFF_LEVEL;
      result_valid <= 1'b0;
    end else begin
      if (in_advance) begin
        held_red     <= held_red_next;
        held_green   <= held_green_next;
        held_blue    <= held_blue_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (in_advance) begin
      result.pwm_red       <= held_red_next;
      result.pwm_green     <= held_green_next;
      result.pwm_blue      <= held_blue_next;
      result.color_written <= (status_next == ST_APPLIED);
      result.frame_status  <= status_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "rgb_voice_command_controller_top_assert.svh"

  // A frame that applies no colour leaves the held colour untouched.
  `RVCC_ASSERT(a_colour_kept, (in_advance && (status_next != ST_APPLIED)) |=> ($stable(held_red) && $stable(held_green) && $stable(held_blue)), "colour changed by a frame that applied nothing")

  // The reported colour is the held colour after each frame.
  `RVCC_ASSERT(a_result_matches_held, $past(in_advance) |-> ((result.pwm_red == held_red) && (result.pwm_green == held_green) && (result.pwm_blue == held_blue)), "result colour differs from held colour")

  // The frame channel is only stalled while a frame waits in the input register.
  `RVCC_ASSERT(a_stall_needs_frame, frame_stall |-> (in_valid && result_valid && result_stall), "frame stalled without a waiting frame")

  // Reset leaves the LED off and no result pending.
  `RVCC_ASSERT_ALWAYS(a_reset_off, rst |=> ((held_red == OFF_LEVEL) && (held_green == OFF_LEVEL) && (held_blue == OFF_LEVEL) && !result_valid), "reset did not switch the LED off")

endmodule

`default_nettype wire
